>>> rtl/rss_pkg.sv
`default_nettype none
package rss_pkg;

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam logic [1:0] MODE_LINE = 2'd0;
  localparam logic [1:0] MODE_PARA = 2'd1;
  localparam logic [1:0] MODE_CHAR = 2'd2;

  localparam logic REG_SPLIT_MODE = 1'b0;
  localparam logic REG_SEPARATOR  = 1'b1;

  localparam logic [1:0] SPLIT_MODE_RESET = MODE_LINE;
  localparam logic [7:0] SEPARATOR_RESET  = CH_LF;

  // result queue: room for two results of one item plus two in flight
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned PTR_W   = $clog2(QDEPTH);
  localparam int unsigned LEVEL_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] rec_char;
    logic       char_valid;
    logic       record_end;
  } result_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               room;
    logic               nonempty;
  } queue_status_t;

endpackage
`default_nettype wire

>>> rtl/rss_ifs.sv
`default_nettype none
interface rss_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

interface rss_rec_if;
  logic       valid;
  logic       ready;
  logic [7:0] rec_char;
  logic       char_valid;
  logic       record_end;

  modport source (output valid, output rec_char, output char_valid, output record_end,
                  input ready);
  modport sink   (input valid, input rec_char, input char_valid, input record_end,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/rss_step.sv
`default_nettype none
module rss_step (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [7:0]          in_char,
  input  wire logic                end_of_input,
  input  wire logic [1:0]          split_mode,
  input  wire logic [7:0]          separator_char,
  output rss_pkg::result_t         res0,
  output rss_pkg::result_t         res1,
  output logic [1:0]               res_count
);
  import rss_pkg::*;

  logic [7:0] held_char, held_char_next;
  logic       held_valid, held_valid_next;
  logic       line_empty, line_empty_next;
  logic       record_started, record_started_next;

  logic    rel, em, fin, clr, drop, hold_en;
  logic    held_live;
  logic    line_empty_step;
  logic [7:0] hold_ch;
  result_t held_res, char_res, end_res;

  // decide which results this character produces: held first, then the
  // character itself, then the end marker
  always_comb begin
    rel       = 1'b0;
    em        = 1'b0;
    fin       = 1'b0;
    clr       = 1'b0;
    drop      = 1'b0;
    hold_en   = 1'b0;
    hold_ch   = CH_CR;
    held_live = held_valid;
    line_empty_step = line_empty;

    if (end_of_input) begin
      if (held_valid || record_started) begin
        rel = held_valid;
        fin = 1'b1;
      end else begin
        clr = 1'b1;
      end
    end else begin
      case (split_mode)
        MODE_CHAR: begin
          rel = held_valid;
          if (in_char == separator_char) begin
            fin = 1'b1;
          end else begin
            em = 1'b1;
            line_empty_step = (in_char == CH_LF);
          end
        end
        MODE_PARA: begin
          if (in_char == CH_LF) begin
            drop      = held_valid && (held_char == CH_CR);
            held_live = held_valid && !drop;
            if (line_empty) begin
              // blank line closes the record; a held LF is trimmed
              fin = held_live || record_started;
            end else begin
              rel     = held_live;
              hold_en = 1'b1;
              hold_ch = CH_LF;
              line_empty_step = 1'b1;
            end
          end else begin
            rel     = held_valid;
            hold_en = (in_char == CH_CR);
            em      = (in_char != CH_CR);
            line_empty_step = 1'b0;
          end
        end
        default: begin
          // newline records; the unused mode code behaves the same
          if (in_char == CH_LF) begin
            drop = held_valid && (held_char == CH_CR);
            rel  = held_valid && !drop;
            fin  = 1'b1;
          end else begin
            rel     = held_valid;
            hold_en = (in_char == CH_CR);
            em      = (in_char != CH_CR);
            line_empty_step = 1'b0;
          end
        end
      endcase
    end
  end

  always_comb begin
    held_res = '{rec_char: held_char, char_valid: 1'b1, record_end: 1'b0};
    char_res = '{rec_char: in_char, char_valid: 1'b1, record_end: 1'b0};
    end_res  = '{rec_char: 8'd0, char_valid: 1'b0, record_end: 1'b1};

    res_count = 2'(rel) + 2'(em) + 2'(fin);
    res1      = end_res;
    if (rel) begin
      res0 = held_res;
      if (em) begin
        res1 = char_res;
      end
    end else if (em) begin
      res0 = char_res;
    end else begin
      res0 = end_res;
    end
  end

  always_comb begin
    held_valid_next     = held_valid;
    held_char_next      = held_char;
    line_empty_next     = line_empty_step;
    record_started_next = record_started || rel || em;
    if (fin || clr) begin
      held_valid_next     = 1'b0;
      held_char_next      = 8'd0;
      line_empty_next     = 1'b1;
      record_started_next = 1'b0;
    end else if (hold_en) begin
      held_valid_next = 1'b1;
      held_char_next  = hold_ch;
    end else if (rel || drop) begin
      held_valid_next = 1'b0;
      held_char_next  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char      <= 8'd0;
      held_valid     <= 1'b0;
      line_empty     <= 1'b1;
      record_started <= 1'b0;
    end else if (accept) begin
      held_char      <= held_char_next;
      held_valid     <= held_valid_next;
      line_empty     <= line_empty_next;
      record_started <= record_started_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rss_queue.sv
`default_nettype none
module rss_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          push_count,
  input  wire rss_pkg::result_t    push0,
  input  wire rss_pkg::result_t    push1,
  input  wire logic                pop,
  output rss_pkg::result_t         head,
  output rss_pkg::queue_status_t   status
);
  import rss_pkg::*;

  result_t            mem [QDEPTH];
  logic [PTR_W-1:0]   rd_ptr, wr_ptr, wr_ptr_nx;
  logic [LEVEL_W-1:0] level;

  assign wr_ptr_nx       = wr_ptr + PTR_W'(1);
  assign head            = mem[rd_ptr];
  assign status.level    = level;
  assign status.nonempty = (level != '0);
  assign status.room     = (level <= LEVEL_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_nx] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      level  <= level + LEVEL_W'(push_count) - LEVEL_W'(pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/record_separator_splitter.sv
`default_nettype none
// Splits a character stream into records: one character per transfer on
// chars, record characters and bare end markers out on records, one result
// per transfer. A character is taken every cycle while the queue has room; the
// state update for it happens at the accepting edge, where its zero to two
// results enter a four-entry result queue. The input stalls only while the
// queue lacks room for two results, which happens when records is
// back-pressured or when characters that produce two results each arrive
// back to back (the single output port then sets the pace). split_mode picks
// newline, paragraph or single-character records; separator_char is the
// separator for the last. Write the registers only while the block is idle.
module record_separator_splitter (
  input  wire logic        clk,
  input  wire logic        rst,
  rss_char_if.sink         chars,
  rss_rec_if.source        records,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rss_pkg::*;

  logic [1:0]    split_mode;
  logic [7:0]    separator_char;
  logic          cfg_write;
  logic          accept;
  logic [1:0]    res_count;
  logic [1:0]    push_count;
  result_t       res0, res1, head;
  queue_status_t qstat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_mode     <= SPLIT_MODE_RESET;
      separator_char <= SEPARATOR_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SPLIT_MODE: split_mode     <= pwdata[1:0];
        REG_SEPARATOR:  separator_char <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SPLIT_MODE: prdata = {30'd0, split_mode};
      REG_SEPARATOR:  prdata = {24'd0, separator_char};
      default:        prdata = 32'd0;
    endcase
  end

  assign chars.ready = qstat.room;
  assign accept      = chars.valid && chars.ready;
  assign push_count  = accept ? res_count : 2'd0;

  rss_step u_step (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .in_char        (chars.in_char),
    .end_of_input   (chars.end_of_input),
    .split_mode     (split_mode),
    .separator_char (separator_char),
    .res0           (res0),
    .res1           (res1),
    .res_count      (res_count)
  );

  rss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (records.valid && records.ready),
    .head       (head),
    .status     (qstat)
  );

  assign records.valid      = qstat.nonempty;
  assign records.rec_char   = head.rec_char;
  assign records.char_valid = head.char_valid;
  assign records.record_end = head.record_end;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.level <= LEVEL_W'(QDEPTH))
    else $error("result queue overflow");

  a_accept_has_room: assert property (@(posedge clk) disable iff (rst)
    accept |=> qstat.level <= LEVEL_W'(QDEPTH))
    else $error("accepted item without room for its results");

  a_end_marker_bare: assert property (@(posedge clk) disable iff (rst)
    records.valid |-> !(records.record_end && records.char_valid))
    else $error("end marker carries a character");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !records.valid && chars.ready)
    else $error("queue not empty after reset");
`endif

endmodule
`default_nettype wire

>>> tb/record_separator_splitter_tb.sv
`timescale 1ns / 100ps
module record_separator_splitter_tb;
  import rss_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_STALL = 400;

  // Predicts the record stream and holds the results still owed by the block.
  class record_split_model;
    logic [1:0] mode;
    logic [7:0] sep;
    logic [7:0] held_char;
    bit held_valid;
    bit line_empty;
    bit record_started;
    result_t expected_recs[$];
    int errors;

    function new();
      mode = SPLIT_MODE_RESET;
      sep = SEPARATOR_RESET;
      errors = 0;
      clear();
    endfunction

    function void clear();
      held_char = 8'd0;
      held_valid = 1'b0;
      line_empty = 1'b1;
      record_started = 1'b0;
    endfunction

    function void push(logic [7:0] ch, logic cv, logic re);
      result_t r;
      r.rec_char = ch;
      r.char_valid = cv;
      r.record_end = re;
      expected_recs.push_back(r);
    endfunction

    function void emit(logic [7:0] ch);
      push(ch, 1'b1, 1'b0);
      record_started = 1'b1;
    endfunction

    function void drop_held();
      held_valid = 1'b0;
      held_char = 8'd0;
    endfunction

    function void release_held();
      if (held_valid) begin
        emit(held_char);
        drop_held();
      end
    endfunction

    function void hold(logic [7:0] ch);
      held_char = ch;
      held_valid = 1'b1;
    endfunction

    function void close_record();
      push(8'd0, 1'b0, 1'b1);
      clear();
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == REG_SPLIT_MODE) mode = val[1:0];
      else sep = val[7:0];
    endfunction

    function int pending();
      return expected_recs.size();
    endfunction

    function void take_char(logic [7:0] c, logic eoi);
      if (eoi) begin
        if (held_valid || record_started) begin
          release_held();
          close_record();
        end else begin
          clear();
        end
        return;
      end
      case (mode)
        MODE_CHAR: begin
          release_held();
          if (c == sep) begin
            close_record();
          end else begin
            emit(c);
            line_empty = (c == CH_LF);
          end
        end
        MODE_PARA: begin
          if (c == CH_LF) begin
            if (held_valid && held_char == CH_CR) drop_held();
            if (line_empty) begin
              // blank line ends the record and trims the held LF;
              // leading LFs of a record are skipped
              if (held_valid || record_started) begin
                drop_held();
                close_record();
              end
            end else begin
              release_held();
              hold(CH_LF);
              line_empty = 1'b1;
            end
          end else begin
            release_held();
            if (c == CH_CR) hold(CH_CR);
            else emit(c);
            line_empty = 1'b0;
          end
        end
        default: begin
          if (c == CH_LF) begin
            if (held_valid && held_char == CH_CR) drop_held();
            else release_held();
            close_record();
          end else begin
            release_held();
            if (c == CH_CR) hold(CH_CR);
            else emit(c);
            line_empty = 1'b0;
          end
        end
      endcase
    endfunction

    function void check_rec(logic [7:0] ch, logic cv, logic re);
      result_t exp_rec;
      if (expected_recs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected record transfer char=%02h valid=%b end=%b",
                   $time, ch, cv, re);
        return;
      end
      exp_rec = expected_recs.pop_front();
      if (ch !== exp_rec.rec_char || cv !== exp_rec.char_valid ||
          re !== exp_rec.record_end) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: record mismatch: expected char=%02h valid=%b end=%b,",
                    " got char=%02h valid=%b end=%b"},
                   $time, exp_rec.rec_char, exp_rec.char_valid, exp_rec.record_end,
                   ch, cv, re);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rss_char_if chars_if ();
  rss_rec_if recs_if ();

  record_separator_splitter u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .records (recs_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  record_split_model splitter_model = new();

  int tx_idle_pct;
  int rx_idle_pct;
  bit long_stall_req;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // record side: random back-pressure, plus one long hold-off on request
  initial begin
    bit stall_done;
    stall_done = 1'b0;
    recs_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req && !stall_done) begin
        recs_if.ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_done = 1'b1;
      end
      recs_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && recs_if.valid && recs_if.ready)
      splitter_model.check_rec(recs_if.rec_char, recs_if.char_valid, recs_if.record_end);
    if (!rst && chars_if.valid && chars_if.ready)
      splitter_model.take_char(chars_if.in_char, chars_if.end_of_input);
  end

  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (recs_if.valid && recs_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < tx_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.in_char <= c;
    chars_if.end_of_input <= eoi;
    do @(posedge clk); while (!chars_if.ready);
    @(negedge clk);
  endtask

  // drop valid and wait until every owed result is out
  task automatic settle();
    chars_if.valid <= 1'b0;
    while (splitter_model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    splitter_model.write_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 22) return CH_LF;
    if (roll < 34) return CH_CR;
    if (roll < 44) return splitter_model.sep;
    if (roll < 60) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h7a, 8'h61));
  endfunction

  task automatic send_random(input int count);
    logic [7:0] c;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 3) begin
        send_char(8'($urandom_range(255)), 1'b1);
      end else begin
        c = pick_char();
        send_char(c, 1'b0);
        // favor CR LF pairs so the CR drop rule gets exercised
        if (c == CH_CR && $urandom_range(99) < 60) send_char(CH_LF, 1'b0);
      end
    end
  endtask

  initial begin
    logic [1:0] phase_mode;
    logic [7:0] phase_sep;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    chars_if.valid = 1'b0;
    chars_if.in_char = 8'd0;
    chars_if.end_of_input = 1'b0;
    tx_idle_pct = 12;
    rx_idle_pct = 60;
    long_stall_req = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // newline records at reset settings: CR before LF, empty record,
    // held CR at end of input, end of an empty stream
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_CR, 1'b0);
    send_char("q", 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);

    // carry a held CR across mode changes
    send_char("k", 1'b0);
    send_char(CH_CR, 1'b0);
    settle();
    apb_write(REG_SPLIT_MODE, 32'(MODE_PARA));
    send_char(CH_LF, 1'b0);
    settle();
    apb_write(REG_SPLIT_MODE, 32'(MODE_CHAR));
    apb_write(REG_SEPARATOR, 32'("#"));
    send_char("x", 1'b0);
    send_char("#", 1'b0);
    send_char("#", 1'b0);
    send_char("a", 1'b0);
    send_char(CH_LF, 1'b0);

    // blank line with nothing held to trim, then leading LF and a paragraph
    settle();
    apb_write(REG_SPLIT_MODE, 32'(MODE_PARA));
    send_char(CH_LF, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char("p", 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char("z", 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(8'h5A, 1'b1);

    settle();
    apb_write(REG_SPLIT_MODE, 32'(MODE_UNUSED));
    send_char("r", 1'b0);
    send_char(CH_CR, 1'b0);
    send_char(CH_LF, 1'b0);

    for (int p = 0; p < 9; p++) begin
      phase_sep = 8'($urandom_range(255));
      case (p)
        0, 7: phase_mode = MODE_LINE;
        1, 5: phase_mode = MODE_PARA;
        4: phase_mode = MODE_UNUSED;
        default: phase_mode = MODE_CHAR;
      endcase
      if (p == 2) phase_sep = 8'h00;
      if (p == 3) phase_sep = 8'hFF;
      if (p == 8) phase_sep = CH_CR;
      tx_idle_pct = (p < 3) ? 12 : (p < 6) ? 60 : 0;
      rx_idle_pct = (p < 3) ? 60 : (p < 6) ? 12 : 0;
      settle();
      apb_write(REG_SPLIT_MODE, 32'(phase_mode));
      apb_write(REG_SEPARATOR, 32'(phase_sep));
      if (p == 6) long_stall_req = 1'b1;
      send_random(100);
    end

    settle();
    repeat (20) @(posedge clk);
    if (splitter_model.errors == 0 && splitter_model.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
